@@ sv/length_prefixed_crc16_receive_deframer_core_assert.svh @@
// Assertion macros used by the checker file.
`ifndef LENGTH_PREFIXED_CRC16_RECEIVE_DEFRAMER_CORE_ASSERT_SVH
`define LENGTH_PREFIXED_CRC16_RECEIVE_DEFRAMER_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define LPD_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while reset is held.
`define LPD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ sv/lpd_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package lpd_pkg;

  localparam logic [15:0] CRC_INIT    = 16'hFFFF;
  localparam logic [15:0] CRC_POLY    = 16'h1021;
  localparam logic [15:0] CRC_TOP     = 16'h8000;
  localparam logic [7:0]  MIN_LEN     = 8'd4;
  localparam logic [7:0]  HEADER_LEN  = 8'd2;
  localparam logic [7:0]  TRAILER_LEN = 8'd2;

  typedef enum logic [1:0] {
    PH_LEN     = 2'd0,
    PH_TYPE    = 2'd1,
    PH_PAYLOAD = 2'd2,
    PH_TRAILER = 2'd3
  } phase_e;

  typedef enum logic [1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_GOOD    = 2'd1,
    KIND_CRC_ERR = 2'd2,
    KIND_BAD_LEN = 2'd3
  } kind_e;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] payload_byte;
    logic [7:0] message_type;
    logic [7:0] payload_index;
    logic [7:0] frame_length;
  } result_t;

  // Byte-parallel CRC-16 update, MSB first, no reflection.
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if ((c & CRC_TOP) != 16'h0000) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

@@ sv/lpd_in_reg.sv @@
`timescale 1ns / 1ps
`default_nettype none

module lpd_in_reg (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] rx_byte_i,
  input  logic       take_i,
  output logic       valid_o,
  output logic [7:0] byte_o
);

  logic       valid_q;
  logic [7:0] byte_q;

  assign in_ready_o = !valid_q || take_i;
  assign valid_o    = valid_q;
  assign byte_o     = byte_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      byte_q <= rx_byte_i;
    end
  end

endmodule

`default_nettype wire

@@ sv/lpd_parser.sv @@
`timescale 1ns / 1ps
`default_nettype none

module lpd_parser (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  logic [7:0]       rx_byte_i,
  output logic             res_valid_o,
  output lpd_pkg::result_t res_o
);

  lpd_pkg::phase_e phase_q, phase_d;
  logic [7:0]      pos_q, pos_d;
  logic [7:0]      len_q, len_d;
  logic [7:0]      type_q, type_d;
  logic [7:0]      trl_q, trl_d;
  logic [15:0]     crc_q, crc_d;
  logic [15:0]     crc_upd;
  logic [7:0]      pos_inc;
  logic [7:0]      len_m2;
  logic            crc_match;

  // The length byte always starts from the initial value.
  assign crc_upd   = lpd_pkg::crc16_byte((phase_q == lpd_pkg::PH_LEN) ? lpd_pkg::CRC_INIT
                                                                      : crc_q, rx_byte_i);
  assign pos_inc   = pos_q + 8'd1;
  assign len_m2    = len_q - lpd_pkg::TRAILER_LEN;
  assign crc_match = ({rx_byte_i, trl_q} == crc_q);

  always_comb begin
    phase_d = phase_q;
    pos_d   = pos_q;
    len_d   = len_q;
    type_d  = type_q;
    trl_d   = trl_q;
    crc_d   = crc_q;
    if (step_i) begin
      unique case (phase_q)
        lpd_pkg::PH_LEN: begin
          // Drop a short length byte and keep waiting.
          if (rx_byte_i >= lpd_pkg::MIN_LEN) begin
            len_d   = rx_byte_i;
            crc_d   = crc_upd;
            pos_d   = 8'd1;
            phase_d = lpd_pkg::PH_TYPE;
          end
        end
        lpd_pkg::PH_TYPE: begin
          type_d  = rx_byte_i;
          crc_d   = crc_upd;
          pos_d   = lpd_pkg::HEADER_LEN;
          phase_d = (len_q == lpd_pkg::MIN_LEN) ? lpd_pkg::PH_TRAILER : lpd_pkg::PH_PAYLOAD;
        end
        lpd_pkg::PH_PAYLOAD: begin
          crc_d = crc_upd;
          pos_d = pos_inc;
          if (pos_inc >= len_m2) begin
            phase_d = lpd_pkg::PH_TRAILER;
          end
        end
        lpd_pkg::PH_TRAILER: begin
          if (pos_q == len_m2) begin
            trl_d = rx_byte_i;
            pos_d = pos_inc;
          end else begin
            phase_d = lpd_pkg::PH_LEN;
            pos_d   = 8'd0;
            crc_d   = lpd_pkg::CRC_INIT;
          end
        end
        default: phase_d = lpd_pkg::PH_LEN;
      endcase
    end
  end

  always_comb begin
    res_valid_o         = 1'b0;
    res_o.kind          = lpd_pkg::KIND_PAYLOAD;
    res_o.payload_byte  = 8'd0;
    res_o.message_type  = type_q;
    res_o.payload_index = 8'd0;
    res_o.frame_length  = len_q;
    if (step_i) begin
      unique case (phase_q)
        lpd_pkg::PH_LEN: begin
          if (rx_byte_i < lpd_pkg::MIN_LEN) begin
            res_valid_o        = 1'b1;
            res_o.kind         = lpd_pkg::KIND_BAD_LEN;
            res_o.message_type = 8'd0;
            res_o.frame_length = rx_byte_i;
          end
        end
        lpd_pkg::PH_TYPE: begin
          res_valid_o = 1'b0;
        end
        lpd_pkg::PH_PAYLOAD: begin
          res_valid_o         = 1'b1;
          res_o.payload_byte  = rx_byte_i;
          res_o.payload_index = pos_q - lpd_pkg::HEADER_LEN;
        end
        lpd_pkg::PH_TRAILER: begin
          if (pos_q != len_m2) begin
            res_valid_o = 1'b1;
            res_o.kind  = crc_match ? lpd_pkg::KIND_GOOD : lpd_pkg::KIND_CRC_ERR;
          end
        end
        default: res_valid_o = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= lpd_pkg::PH_LEN;
      pos_q   <= 8'd0;
      len_q   <= 8'd0;
      type_q  <= 8'd0;
      trl_q   <= 8'd0;
      crc_q   <= lpd_pkg::CRC_INIT;
    end else begin
      phase_q <= phase_d;
      pos_q   <= pos_d;
      len_q   <= len_d;
      type_q  <= type_d;
      trl_q   <= trl_d;
      crc_q   <= crc_d;
    end
  end

endmodule

`default_nettype wire

@@ sv/lpd_out_reg.sv @@
`timescale 1ns / 1ps
`default_nettype none

module lpd_out_reg (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             load_i,
  input  lpd_pkg::result_t res_i,
  input  logic             ready_i,
  output logic             space_o,
  output logic             valid_o,
  output lpd_pkg::result_t res_o
);

  logic             valid_q;
  lpd_pkg::result_t res_q;

  assign space_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign res_o   = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

endmodule

`default_nettype wire

@@ sv/length_prefixed_crc16_receive_deframer_core.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Receive deframer for length-prefixed frames with a CRC-16 (poly 0x1021, init 0xFFFF)
// trailer. One byte enters per cycle. It is captured in an input register, and the frame
// state machine and a byte-parallel CRC update process it once the output register has
// room. A result lands in an output register and can be taken at the next clock edge.
// Throughput is one byte per clock while the output is not stalled, set by the
// combinational CRC update that feeds back into the running CRC register. While an
// untaken result sits in the output register, the held byte waits and the input
// stalls; in_ready_o depends combinationally on out_ready_i. Payload bytes are passed
// out unverified as kind 0. The last trailer byte gives one verdict. A length byte
// below four gives a bad-length result and is dropped.
module length_prefixed_crc16_receive_deframer_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] rx_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [1:0] kind_o,
  output logic [7:0] payload_byte_o,
  output logic [7:0] message_type_o,
  output logic [7:0] payload_index_o,
  output logic [7:0] frame_length_o
);

  logic             byte_valid;
  logic [7:0]       byte_q;
  logic             space;
  logic             step;
  logic             res_valid;
  lpd_pkg::result_t res;
  lpd_pkg::result_t out_res;

  // Advance a byte only when the output register can hold its result.
  assign step = byte_valid && space;

  lpd_in_reg u_in_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .rx_byte_i  (rx_byte_i),
    .take_i     (step),
    .valid_o    (byte_valid),
    .byte_o     (byte_q)
  );

  lpd_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .rx_byte_i   (byte_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  lpd_out_reg u_out_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (step && res_valid),
    .res_i   (res),
    .ready_i (out_ready_i),
    .space_o (space),
    .valid_o (out_valid_o),
    .res_o   (out_res)
  );

  assign kind_o          = out_res.kind;
  assign payload_byte_o  = out_res.payload_byte;
  assign message_type_o  = out_res.message_type;
  assign payload_index_o = out_res.payload_index;
  assign frame_length_o  = out_res.frame_length;

endmodule

`default_nettype wire

@@ sv/lpd_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none

`include "length_prefixed_crc16_receive_deframer_core_assert.svh"

module lpd_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [1:0] kind_o,
  input logic [7:0] payload_byte_o,
  input logic [7:0] message_type_o,
  input logic [7:0] payload_index_o,
  input logic [7:0] frame_length_o
);

  logic        out_stall;
  logic        res_not_payload;
  logic        res_bad_len;
  logic        non_payload_ok;
  logic        bad_len_ok;
  logic [33:0] out_bundle;

  assign out_stall       = out_valid_o && !out_ready_i;
  assign res_not_payload = out_valid_o && (kind_o != lpd_pkg::KIND_PAYLOAD);
  assign res_bad_len     = out_valid_o && (kind_o == lpd_pkg::KIND_BAD_LEN);
  assign non_payload_ok  = (payload_byte_o == 8'd0) && (payload_index_o == 8'd0);
  assign bad_len_ok      = (frame_length_o < lpd_pkg::MIN_LEN) && (message_type_o == 8'd0);
  assign out_bundle      = {kind_o, payload_byte_o, message_type_o, payload_index_o,
                            frame_length_o};

  `LPD_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_stall, out_valid_o)

  `LPD_ASSERT_NEXT(a_out_stable, clk_i, rst_ni, out_stall, $stable(out_bundle))

  `LPD_ASSERT_NOW(a_non_payload_zero, clk_i, rst_ni, res_not_payload, non_payload_ok)

  `LPD_ASSERT_NOW(a_bad_len_fields, clk_i, rst_ni, res_bad_len, bad_len_ok)

  `LPD_ASSERT_NOW(a_len_valid_frame, clk_i, rst_ni, out_valid_o && !res_bad_len, frame_length_o >= lpd_pkg::MIN_LEN)

endmodule

bind length_prefixed_crc16_receive_deframer_core lpd_checker u_lpd_checker (.*);

`default_nettype wire

@@ test/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
  import lpd_pkg::*;

  localparam int unsigned TARGET_BYTES = 1350;
  localparam int unsigned QUIET_TAIL   = 150;
  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned DRAIN_CYCLES = 20;

  logic       clk_i        = 1'b0;
  logic       rst_ni       = 1'b0;
  logic       in_valid_i   = 1'b0;
  logic       in_ready_o;
  logic [7:0] rx_byte_i    = 8'h00;
  logic       out_valid_o;
  logic       out_ready_i  = 1'b0;
  logic [1:0] kind_o;
  logic [7:0] payload_byte_o;
  logic [7:0] message_type_o;
  logic [7:0] payload_index_o;
  logic [7:0] frame_length_o;

  length_prefixed_crc16_receive_deframer_core dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .rx_byte_i       (rx_byte_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .kind_o          (kind_o),
    .payload_byte_o  (payload_byte_o),
    .message_type_o  (message_type_o),
    .payload_index_o (payload_index_o),
    .frame_length_o  (frame_length_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Byte stream waiting to be sent, and deframer results still owed by the DUT
  logic [7:0]  pending_bytes[$];
  result_t     expected_results[$];
  int unsigned total_bytes    = 0;
  int unsigned bytes_accepted = 0;
  int unsigned cycle_count    = 0;
  int unsigned mismatches     = 0;
  int unsigned n_payload      = 0;
  int unsigned n_good         = 0;
  int unsigned n_crc_err      = 0;
  int unsigned n_bad_len      = 0;
  int unsigned longest_frame  = 0;

  // Deframer state as predicted from the accepted bytes
  phase_e      rx_phase    = PH_LEN;
  logic [7:0]  rx_pos      = 8'd0;
  logic [7:0]  rx_len      = 8'd0;
  logic [15:0] rx_crc      = CRC_INIT;
  logic [7:0]  rx_type     = 8'd0;
  logic [7:0]  rx_trail_lo = 8'd0;

  // Idle control
  int unsigned in_gap   = 0;
  int unsigned out_gap  = 0;
  bit          in_calm  = 1'b0;
  bit          out_calm = 1'b0;
  bit          quiet;

  assign quiet = (bytes_accepted + QUIET_TAIL >= total_bytes);

  // Bit-serial CRC-16, MSB first
  function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    logic        fb;
    c = crc;
    for (int i = 7; i >= 0; i--) begin
      fb = c[15] ^ b[i];
      c = {c[14:0], 1'b0} ^ (fb ? CRC_POLY : 16'h0000);
    end
    return c;
  endfunction

  function automatic void predict_byte(input logic [7:0] b);
    result_t r;
    r = '0;
    case (rx_phase)
      PH_LEN: begin
        if (b < MIN_LEN) begin
          r.kind = KIND_BAD_LEN;
          r.frame_length = b;
          expected_results.push_back(r);
        end else begin
          rx_len   = b;
          rx_crc   = crc_step(CRC_INIT, b);
          rx_pos   = 8'd1;
          rx_phase = PH_TYPE;
        end
      end
      PH_TYPE: begin
        rx_type  = b;
        rx_crc   = crc_step(rx_crc, b);
        rx_pos   = HEADER_LEN;
        rx_phase = (rx_len == MIN_LEN) ? PH_TRAILER : PH_PAYLOAD;
      end
      PH_PAYLOAD: begin
        rx_crc = crc_step(rx_crc, b);
        r.kind          = KIND_PAYLOAD;
        r.payload_byte  = b;
        r.message_type  = rx_type;
        r.payload_index = rx_pos - HEADER_LEN;
        r.frame_length  = rx_len;
        expected_results.push_back(r);
        rx_pos = rx_pos + 8'd1;
        if (rx_pos >= rx_len - TRAILER_LEN) rx_phase = PH_TRAILER;
      end
      default: begin
        if (rx_pos == rx_len - TRAILER_LEN) begin
          rx_trail_lo = b;
          rx_pos = rx_pos + 8'd1;
        end else begin
          r.kind = ({b, rx_trail_lo} == rx_crc) ? KIND_GOOD : KIND_CRC_ERR;
          r.message_type = rx_type;
          r.frame_length = rx_len;
          expected_results.push_back(r);
          rx_phase = PH_LEN;
          rx_pos   = 8'd0;
          rx_crc   = CRC_INIT;
        end
      end
    endcase
  endfunction

  function automatic void queue_byte(input logic [7:0] b);
    pending_bytes.push_back(b);
    total_bytes++;
  endfunction

  // Build one frame; payload is random when fill is negative. Spoil breaks the CRC
  // without touching the length byte.
  function automatic void queue_frame(input int unsigned len, input logic [7:0] mtype,
                                      input int fill, input bit spoil);
    logic [7:0]  body[$];
    logic [15:0] c;
    int unsigned k;
    body.push_back(len[7:0]);
    body.push_back(mtype);
    for (k = 0; k + 4 < len; k++)
      body.push_back((fill < 0) ? 8'($urandom_range(0, 255)) : fill[7:0]);
    c = CRC_INIT;
    foreach (body[i]) c = crc_step(c, body[i]);
    if (spoil) begin
      if ($urandom_range(0, 1) == 0) begin
        k = $urandom_range(1, body.size() - 1);
        body[k] = body[k] ^ (8'd1 << $urandom_range(0, 7));
      end else begin
        c = c ^ 16'($urandom_range(1, 16'hFFFF));
      end
    end
    foreach (body[i]) queue_byte(body[i]);
    queue_byte(c[7:0]);
    queue_byte(c[15:8]);
  endfunction

  task automatic log_mismatch(input string why, input result_t want);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%0t: %s", $time, why);
      $display("  expected kind=%0d byte=%02h type=%02h idx=%0d len=%0d",
               want.kind, want.payload_byte, want.message_type, want.payload_index,
               want.frame_length);
      $display("  actual   kind=%0d byte=%02h type=%02h idx=%0d len=%0d",
               kind_o, payload_byte_o, message_type_o, payload_index_o, frame_length_o);
    end
  endtask

  // Input side: present queued bytes, hold until accepted, idle in bursts
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        predict_byte(rx_byte_i);
        bytes_accepted++;
      end
      if ($urandom_range(0, 63) == 0) in_calm = !in_calm;
      if (!(in_valid_i && !in_ready_o)) begin
        if (in_gap > 0) begin
          in_gap--;
          in_valid_i <= 1'b0;
        end else if (pending_bytes.size() != 0 && !quiet && !in_calm &&
                     $urandom_range(0, 7) == 0) begin
          in_gap = $urandom_range(1, 13) - 1;
          in_valid_i <= 1'b0;
        end else if (pending_bytes.size() != 0) begin
          in_valid_i <= 1'b1;
          rx_byte_i  <= pending_bytes.pop_front();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Output side: check each transaction against the oldest expectation
  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (expected_results.size() == 0) begin
          log_mismatch("result with nothing expected", '0);
        end else begin
          want = expected_results.pop_front();
          if (kind_o !== want.kind || payload_byte_o !== want.payload_byte ||
              message_type_o !== want.message_type ||
              payload_index_o !== want.payload_index ||
              frame_length_o !== want.frame_length)
            log_mismatch("result differs", want);
          case (want.kind)
            KIND_PAYLOAD: n_payload++;
            KIND_GOOD:    n_good++;
            KIND_CRC_ERR: n_crc_err++;
            default:      n_bad_len++;
          endcase
          if (want.kind != KIND_BAD_LEN && want.frame_length > longest_frame)
            longest_frame = want.frame_length;
        end
      end
      if ($urandom_range(0, 63) == 0) out_calm = !out_calm;
      if (out_gap > 0) begin
        out_gap--;
        out_ready_i <= 1'b0;
      end else if (!quiet && !out_calm && $urandom_range(0, 7) == 0) begin
        out_gap = $urandom_range(1, 13) - 1;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding", cycle_count,
               expected_results.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    int unsigned pick;
    int unsigned len;
    int unsigned k;

    // Lengths under four are rejected one byte at a time
    for (k = 0; k < MIN_LEN; k++) queue_byte(k[7:0]);
    // Empty payload, a single 0xFF payload byte, then a broken CRC on a two-byte zero payload
    queue_frame(4, 8'h00, -1, 1'b0);
    queue_frame(5, 8'hFF, 255, 1'b0);
    queue_frame(6, 8'hA5, 0, 1'b1);

    // Longest frame reaches the top payload index
    queue_frame(255, 8'($urandom_range(0, 255)), -1, 1'b0);
    while (total_bytes < TARGET_BYTES) begin
      pick = $urandom_range(0, 99);
      if (pick < 85) begin
        len = ($urandom_range(0, 49) == 0) ? $urandom_range(128, 255) : $urandom_range(4, 20);
        queue_frame(len, 8'($urandom_range(0, 255)), -1, $urandom_range(0, 3) == 0);
      end else if (pick < 93) begin
        queue_byte(8'($urandom_range(0, 3)));
      end else if (pick < 97) begin
        // Noise: a stray length byte is trusted and reframes what follows
        len = $urandom_range(1, 4);
        for (k = 0; k < len; k++) queue_byte(8'($urandom_range(0, 255)));
      end else begin
        // Truncated frame: header and part of the payload only
        len = $urandom_range(6, 20);
        queue_byte(len[7:0]);
        queue_byte(8'($urandom_range(0, 255)));
        for (k = 0; k < $urandom_range(0, len - 5); k++)
          queue_byte(8'($urandom_range(0, 255)));
      end
    end

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    do @(negedge clk_i); while (bytes_accepted < total_bytes);
    do @(negedge clk_i); while (expected_results.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk_i);

    $display("Sent %0d bytes: %0d payload results, %0d good frames, %0d CRC errors,",
             total_bytes, n_payload, n_good, n_crc_err);
    $display("%0d rejected lengths, longest frame %0d bytes, %0d mismatches",
             n_bad_len, longest_frame, mismatches);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+sv
sv/lpd_pkg.sv
sv/lpd_in_reg.sv
sv/lpd_parser.sv
sv/lpd_out_reg.sv
sv/length_prefixed_crc16_receive_deframer_core.sv
sv/lpd_checker.sv
test/testbench.sv
